// ----- hdl/owm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Mode codes, command codes, register indexes, timing defaults and CRC-8.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned TimeW = 10;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_SHORT_LOW     = 3'd3,
    CFG_ZERO_LOW      = 3'd4,
    CFG_WRITE_SLOT    = 3'd5,
    CFG_READ_SAMPLE   = 3'd6,
    CFG_READ_TAIL     = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] PhaseLow    = 2'd0;
  localparam logic [1:0] PhaseWait   = 2'd1;
  localparam logic [1:0] PhaseTail   = 2'd2;
  localparam logic [2:0] LastBit     = 3'd7;
  localparam logic [7:0] CrcPoly     = 8'h8c;

  localparam logic [TimeW-1:0] ResetLowInit     = 10'd480;
  localparam logic [TimeW-1:0] PresenceWaitInit = 10'd70;
  localparam logic [TimeW-1:0] ResetTailInit    = 10'd410;
  localparam logic [TimeW-1:0] ShortLowInit     = 10'd6;
  localparam logic [TimeW-1:0] ZeroLowInit      = 10'd60;
  localparam logic [TimeW-1:0] WriteSlotInit    = 10'd70;
  localparam logic [TimeW-1:0] ReadSampleInit   = 10'd9;
  localparam logic [TimeW-1:0] ReadTailInit     = 10'd55;

  typedef struct packed {
    logic [TimeW-1:0] reset_low;
    logic [TimeW-1:0] presence_wait;
    logic [TimeW-1:0] reset_tail;
    logic [TimeW-1:0] short_low;
    logic [TimeW-1:0] zero_low;
    logic [TimeW-1:0] write_slot;
    logic [TimeW-1:0] read_sample;
    logic [TimeW-1:0] read_tail;
  } owm_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       present;
    logic [7:0] crc;
  } owm_res_t;

  // Fold one byte into the reflected Dallas CRC-8.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

endpackage

// ----- hdl/onewire_bus_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master: 1-Wire bus master stepped by microsecond ticks
// Each request is one tick; it may start a reset pulse, a byte write or a
// byte read, and yields one result with line drive and status.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        request    in_valid_i / in_stall_o    op_i, write_byte_i, line_in_i
//  out       result     out_valid_o / out_stall_i  drive_low_o .. crc_value_o
//  cfg       write      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low: the sequencer steps its state
// on the accepting edge and loads the result register at the same edge; the
// result appears in the cycle after acceptance. Reset restores the default
// timings and idles the sequencer. While the result register is full and
// out_stall_i is high, in_stall_o holds incoming requests. Configuration
// writes are taken in every cycle.
module onewire_bus_master import owm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tick requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         write_byte_i,
  input  logic               line_in_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         read_data_o,
  output logic               device_present_o,
  output logic [7:0]         crc_value_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  owm_cfg_t cfg_q;
  owm_res_t res, res_q;
  logic     accept;
  logic     out_valid_q, out_valid_d;

  // Timing registers: always ready, write the addressed register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{reset_low: ResetLowInit, presence_wait: PresenceWaitInit,
                 reset_tail: ResetTailInit, short_low: ShortLowInit,
                 zero_low: ZeroLowInit, write_slot: WriteSlotInit,
                 read_sample: ReadSampleInit, read_tail: ReadTailInit};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_data_i;
        CFG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data_i;
        CFG_RESET_TAIL:    cfg_q.reset_tail    <= cfg_data_i;
        CFG_SHORT_LOW:     cfg_q.short_low     <= cfg_data_i;
        CFG_ZERO_LOW:      cfg_q.zero_low      <= cfg_data_i;
        CFG_WRITE_SLOT:    cfg_q.write_slot    <= cfg_data_i;
        CFG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data_i;
        CFG_READ_TAIL:     cfg_q.read_tail     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold requests only while a waiting result cannot leave.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  owm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .op_i         (op_i),
    .write_byte_i (write_byte_i),
    .line_in_i    (line_in_i),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // Result register: load on accept, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = res_q.drive_low;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign read_data_o      = res_q.read_data;
  assign device_present_o = res_q.present;
  assign crc_value_o      = res_q.crc;

endmodule

// ----- hdl/owm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_core: 1-Wire slot sequencer
// Holds mode, phase, tick and bit counters, shift and result state; advances
// by one microsecond tick on each step.
// ----------------------------------------------------------------------------
module owm_core import owm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] op_i,
  input  logic [7:0] write_byte_i,
  input  logic       line_in_i,
  input  owm_cfg_t   cfg_i,
  output owm_res_t   res_o
);

  mode_e            mode_q, mode_d, mode_eff;
  logic [1:0]       phase_q, phase_d, phase_cur;
  logic [TimeW-1:0] tick_q, tick_d, tick_cur, tick_inc, len;
  logic [2:0]       bit_q, bit_d, bit_cur;
  logic [7:0]       shift_q, shift_d, shift_cur;
  logic [7:0]       last_q, last_d;
  logic [7:0]       crc_q, crc_d, crc_cur;
  logic             pres_q, pres_d;
  logic             start, phase_end;
  logic             busy, drive, done;
  logic [TimeW-1:0] low_len;

  // Start-of-command view of the state and the current phase length.
  always_comb begin
    start     = (mode_q == MODE_IDLE) && (op_e'(op_i) != OP_TICK);
    mode_eff  = start ? mode_e'(op_i) : mode_q;
    phase_cur = start ? PhaseLow : phase_q;
    tick_cur  = start ? '0 : tick_q;
    bit_cur   = start ? 3'd0 : bit_q;
    shift_cur = start ? ((op_e'(op_i) == OP_WRITE) ? write_byte_i : 8'h00) : shift_q;
    crc_cur   = (start && (op_e'(op_i) == OP_RESET)) ? 8'h00 : crc_q;
    low_len   = shift_cur[0] ? cfg_i.short_low : cfg_i.zero_low;
    case (mode_eff)
      MODE_RESET: begin
        len = (phase_cur == PhaseLow)  ? cfg_i.reset_low :
              (phase_cur == PhaseWait) ? cfg_i.presence_wait : cfg_i.reset_tail;
      end
      MODE_WRITE: begin
        if (phase_cur == PhaseLow) begin
          len = low_len;
        end else begin
          len = (cfg_i.write_slot > low_len) ? (cfg_i.write_slot - low_len)
                                             : TimeW'(1);
        end
      end
      MODE_READ: begin
        len = (phase_cur == PhaseLow)  ? cfg_i.short_low :
              (phase_cur == PhaseWait) ? cfg_i.read_sample : cfg_i.read_tail;
      end
      default: len = '0;
    endcase
    tick_inc  = tick_cur + TimeW'(1);
    phase_end = (mode_eff != MODE_IDLE) && (tick_inc >= len);
  end

  // Outputs of this tick.
  always_comb begin
    busy = (mode_eff != MODE_IDLE);
    drive = busy && (phase_cur == PhaseLow);
    done = 1'b0;
    if (phase_end) begin
      case (mode_eff)
        MODE_RESET: done = (phase_cur == PhaseTail);
        MODE_WRITE: done = (phase_cur != PhaseLow) && (bit_cur == LastBit);
        MODE_READ:  done = (phase_cur == PhaseTail) && (bit_cur == LastBit);
        default:    done = 1'b0;
      endcase
    end
  end

  // Next state.
  always_comb begin
    mode_d  = mode_eff;
    phase_d = phase_cur;
    tick_d  = busy ? tick_inc : tick_cur;
    bit_d   = bit_cur;
    shift_d = shift_cur;
    last_d  = last_q;
    crc_d   = crc_cur;
    pres_d  = pres_q;
    if (phase_end) begin
      tick_d = '0;
      case (mode_eff)
        MODE_RESET: begin
          if (phase_cur == PhaseLow) begin
            phase_d = PhaseWait;
          end else if (phase_cur == PhaseWait) begin
            pres_d  = ~line_in_i;
            phase_d = PhaseTail;
          end
        end
        MODE_WRITE: begin
          if (phase_cur == PhaseLow) begin
            phase_d = PhaseWait;
          end else begin
            shift_d = shift_cur >> 1;
            phase_d = PhaseLow;
            bit_d   = bit_cur + 3'd1;
          end
        end
        MODE_READ: begin
          if (phase_cur == PhaseLow) begin
            phase_d = PhaseWait;
          end else if (phase_cur == PhaseWait) begin
            shift_d = shift_cur | (8'(line_in_i) << bit_cur);
            phase_d = PhaseTail;
          end else begin
            phase_d = PhaseLow;
            if (bit_cur == LastBit) begin
              last_d = shift_cur;
              crc_d  = crc_fold(crc_cur, shift_cur);
            end
            bit_d = bit_cur + 3'd1;
          end
        end
        default: ;
      endcase
      if (done) begin
        mode_d  = MODE_IDLE;
        phase_d = PhaseLow;
        bit_d   = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PhaseLow;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'h00;
      last_q  <= 8'h00;
      crc_q   <= 8'h00;
      pres_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      last_q  <= last_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
    end
  end

  assign res_o = '{drive_low: drive, busy: busy, done: done, read_data: last_d,
                   present: pres_d, crc: crc_d};

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 1-Wire bus master tick sequencer
// Drives tick requests with random gaps, stalls the result side at random,
// predicts line drive, status, read byte, presence and CRC for every tick,
// and walks the timing registers through zero, minimum, short-slot and random sets.
// ----------------------------------------------------------------------------
module tb import owm_pkg::*; ();

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 5;
  localparam int IdlePct     = 29;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 90;
  localparam int RandSets    = 3;
  localparam int TicksPerSet = 50;
  localparam int MaxReports  = 100;

  typedef enum logic [1:0] {
    LINE_LOW,
    LINE_HIGH,
    LINE_RANDOM
  } line_pat_e;

  // Tracks the bus sequencer tick by tick and holds the status words that
  // the block owes, oldest first.
  class ow_tick_tracker;
    logic [TimeW-1:0] timing [NumCfg];
    mode_e            mode;
    logic [1:0]       phase;
    logic [TimeW-1:0] ticks;
    logic [2:0]       bit_idx;
    logic [7:0]       shifter;
    logic [7:0]       last_byte;
    logic [7:0]       crc;
    logic             present;
    owm_res_t         owed [$];
    int               errors;
    int               noted;
    int               checked;
    int               starts [4];

    function new();
      timing[CFG_RESET_LOW]     = ResetLowInit;
      timing[CFG_PRESENCE_WAIT] = PresenceWaitInit;
      timing[CFG_RESET_TAIL]    = ResetTailInit;
      timing[CFG_SHORT_LOW]     = ShortLowInit;
      timing[CFG_ZERO_LOW]      = ZeroLowInit;
      timing[CFG_WRITE_SLOT]    = WriteSlotInit;
      timing[CFG_READ_SAMPLE]   = ReadSampleInit;
      timing[CFG_READ_TAIL]     = ReadTailInit;
      mode      = MODE_IDLE;
      phase     = PhaseLow;
      ticks     = '0;
      bit_idx   = '0;
      shifter   = '0;
      last_byte = '0;
      crc       = '0;
      present   = 1'b0;
      errors    = 0;
      noted     = 0;
      checked   = 0;
      foreach (starts[i]) starts[i] = 0;
    endfunction

    function void set_timing(cfg_idx_e idx, logic [TimeW-1:0] val);
      timing[idx] = val;
    endfunction

    function bit busy();
      return mode != MODE_IDLE;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Bit-serial Dallas CRC, LSB first.
    function logic [7:0] crc_byte(logic [7:0] acc, logic [7:0] data);
      logic fb;
      for (int b = 0; b < 8; b++) begin
        fb  = acc[0] ^ data[b];
        acc = acc >> 1;
        if (fb) acc = acc ^ CrcPoly;
      end
      return acc;
    endfunction

    function logic [TimeW-1:0] phase_ticks();
      logic [TimeW-1:0] low;
      case (mode)
        MODE_RESET: begin
          if (phase == PhaseLow) return timing[CFG_RESET_LOW];
          if (phase == PhaseWait) return timing[CFG_PRESENCE_WAIT];
          return timing[CFG_RESET_TAIL];
        end
        MODE_WRITE: begin
          low = shifter[0] ? timing[CFG_SHORT_LOW] : timing[CFG_ZERO_LOW];
          if (phase == PhaseLow) return low;
          return (timing[CFG_WRITE_SLOT] > low) ? timing[CFG_WRITE_SLOT] - low
                                                : TimeW'(1);
        end
        default: begin
          if (phase == PhaseLow) return timing[CFG_SHORT_LOW];
          if (phase == PhaseWait) return timing[CFG_READ_SAMPLE];
          return timing[CFG_READ_TAIL];
        end
      endcase
    endfunction

    // Advance the sequencer by one accepted tick and queue its status word.
    function void note_tick(op_e op, logic [7:0] wbyte, logic line);
      owm_res_t st;
      logic     fin;
      st  = '0;
      fin = 1'b0;
      noted++;
      if (mode == MODE_IDLE && op != OP_TICK) begin
        mode    = mode_e'(op);
        phase   = PhaseLow;
        ticks   = '0;
        bit_idx = '0;
        if (op == OP_RESET) crc = '0;
        shifter = (op == OP_WRITE) ? wbyte : 8'h00;
        starts[op]++;
      end
      if (mode != MODE_IDLE) begin
        st.busy      = 1'b1;
        st.drive_low = (phase == PhaseLow);
        ticks        = ticks + 1'b1;
        if (ticks >= phase_ticks()) begin
          ticks = '0;
          case (mode)
            MODE_RESET: begin
              if (phase == PhaseLow) begin
                phase = PhaseWait;
              end else if (phase == PhaseWait) begin
                present = ~line;
                phase   = PhaseTail;
              end else begin
                fin = 1'b1;
              end
            end
            MODE_WRITE: begin
              if (phase == PhaseLow) begin
                phase = PhaseWait;
              end else begin
                shifter = shifter >> 1;
                phase   = PhaseLow;
                fin     = (bit_idx == LastBit);
                bit_idx = bit_idx + 1'b1;
              end
            end
            default: begin
              if (phase == PhaseLow) begin
                phase = PhaseWait;
              end else if (phase == PhaseWait) begin
                shifter[bit_idx] = shifter[bit_idx] | line;
                phase = PhaseTail;
              end else begin
                phase = PhaseLow;
                if (bit_idx == LastBit) begin
                  fin       = 1'b1;
                  last_byte = shifter;
                  crc       = crc_byte(crc, shifter);
                end
                bit_idx = bit_idx + 1'b1;
              end
            end
          endcase
          if (fin) begin
            mode    = MODE_IDLE;
            phase   = PhaseLow;
            bit_idx = '0;
          end
        end
      end
      st.done      = fin;
      st.read_data = last_byte;
      st.present   = present;
      st.crc       = crc;
      owed.push_back(st);
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        else if (errors == MaxReports + 1)
          $display("%0t: further field errors not printed", $time);
      end
    endfunction

    function void check_result(owm_res_t got);
      owm_res_t want;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with no tick pending, expected none actual %0h", $time, got);
        return;
      end
      want = owed.pop_front();
      report("drive_low", want.drive_low, got.drive_low);
      report("busy", want.busy, got.busy);
      report("done", want.done, got.done);
      report("read_data", want.read_data, got.read_data);
      report("device_present", want.present, got.present);
      report("crc_value", want.crc, got.crc);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic [7:0]         write_byte_i;
  logic               line_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               drive_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [7:0]         read_data_o;
  logic               device_present_o;
  logic [7:0]         crc_value_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [TimeW-1:0]   cfg_data_i;

  ow_tick_tracker   tracker = new();
  logic [TimeW-1:0] plan [NumCfg];
  owm_res_t         seen;
  bit               calm = 1'b0;     // no idling on either side while set
  int               hold_mark = 0;   // result count that starts the long hold-off
  int               timing_sets = 0;
  int               cycle_count = 0;

  onewire_bus_master dut (.*);

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results owed", cycle_count,
               tracker.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the result register
  // fills and the block pushes back on incoming ticks.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && hold_mark != 0 && tracker.checked >= hold_mark) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Sample accepted results on the rising edge and check them in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.drive_low = drive_low_o;
      seen.busy      = busy_res_o;
      seen.done      = done_res_o;
      seen.read_data = read_data_o;
      seen.present   = device_present_o;
      seen.crc       = crc_value_o;
      tracker.check_result(seen);
    end
  end

  function automatic logic line_level(line_pat_e pat);
    if (pat == LINE_LOW) return 1'b0;
    if (pat == LINE_HIGH) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [TimeW-1:0] rand_span();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return TimeW'($urandom_range(20, 7));
    return TimeW'($urandom_range(5, 1));
  endfunction

  // Offer one tick request; call at a falling edge, returns at a falling edge.
  task automatic send_tick(op_e op, logic [7:0] wbyte, logic line);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    write_byte_i <= wbyte;
    line_in_i    <= line;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_tick(op, wbyte, line);
    @(negedge clk_i);
  endtask

  // Start one operation from idle and tick it through to completion; the
  // ticks in between carry random commands, which the block must ignore.
  task automatic run_op(op_e op, logic [7:0] wbyte, line_pat_e pat);
    send_tick(op, wbyte, line_level(pat));
    while (tracker.busy())
      send_tick(op_e'($urandom_range(3)), 8'($urandom), line_level(pat));
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write every timing register from plan; the block is idle here.
  task automatic load_timing();
    for (int i = 0; i < NumCfg; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_timing(cfg_idx_e'(i), plan[i]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    timing_sets++;
  endtask

  task automatic fill_plan(logic [TimeW-1:0] val);
    foreach (plan[i]) plan[i] = val;
  endtask

  initial begin
    op_e op;
    in_valid_i   = 1'b0;
    op_i         = OP_TICK;
    write_byte_i = '0;
    line_in_i    = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_RESET_LOW;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle ticks straight out of reset.
    repeat (3) send_tick(OP_TICK, 8'($urandom), 1'($urandom_range(1)));
    settle();

    // Zero length everywhere, no idling: each phase lasts one tick, and the
    // write slot release falls back to one tick. Read all ones and all zeros,
    // and hold the line low through the reset so a device shows present.
    calm = 1'b1;
    fill_plan('0);
    load_timing();
    run_op(OP_WRITE, 8'h00, LINE_RANDOM);
    run_op(OP_WRITE, 8'hff, LINE_RANDOM);
    run_op(OP_READ, 8'h00, LINE_HIGH);
    run_op(OP_READ, 8'h00, LINE_LOW);
    run_op(OP_RESET, 8'h00, LINE_LOW);
    settle();

    // Legal minimum timings, and a reset with nobody answering.
    fill_plan(10'd1);
    plan[CFG_WRITE_SLOT] = 10'd2;
    load_timing();
    run_op(OP_WRITE, 8'h3c, LINE_RANDOM);
    run_op(OP_READ, 8'h00, LINE_RANDOM);
    run_op(OP_READ, 8'h00, LINE_RANDOM);
    run_op(OP_RESET, 8'hff, LINE_HIGH);
    settle();
    calm = 1'b0;

    // Write slot shorter than the zero low time.
    fill_plan(10'd2);
    plan[CFG_ZERO_LOW]   = 10'd5;
    plan[CFG_WRITE_SLOT] = 10'd3;
    load_timing();
    run_op(OP_WRITE, 8'h0f, LINE_RANDOM);
    settle();

    // Random timing sets with random traffic; commands land both while idle
    // and while busy. One set carries the long result-side hold-off.
    for (int s = 0; s < RandSets; s++) begin
      foreach (plan[i]) plan[i] = rand_span();
      plan[CFG_WRITE_SLOT] = TimeW'($urandom_range(14));
      load_timing();
      for (int k = 0; k < TicksPerSet; k++) begin
        if (!tracker.busy() && $urandom_range(99) < 30) op = OP_TICK;
        else op = op_e'($urandom_range(3));
        if (s == 1 && k == 10) hold_mark = tracker.checked + 4;
        send_tick(op, 8'($urandom), 1'($urandom_range(1)));
      end
      while (tracker.busy())
        send_tick(op_e'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
      settle();
    end

    // Let any stray result show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d results over %0d timing sets",
             tracker.noted, tracker.checked, timing_sets);
    $display("Operations started: %0d reset, %0d write, %0d read",
             tracker.starts[OP_RESET], tracker.starts[OP_WRITE],
             tracker.starts[OP_READ]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
